// ===== src/lpcc_pkg.sv =====
// Shared types, constants and lookup functions of the charlieplex LED controller.
package lpcc_pkg;

  localparam int LED_COUNT = 20;
  localparam int LED_IDX_W = $clog2(LED_COUNT);
  localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(LED_COUNT - 1);
  localparam logic [LED_COUNT-1:0] ALL_LEDS = '1;
  localparam logic [15:0] NOISE_SEED = 16'h1234;

  localparam logic [2:0] MODE_OFF          = 3'd0;
  localparam logic [2:0] MODE_ON           = 3'd1;
  localparam logic [2:0] MODE_BLINK        = 3'd2;
  localparam logic [2:0] MODE_MARQUEE      = 3'd3;
  localparam logic [2:0] MODE_RFILL        = 3'd4;
  localparam logic [2:0] MODE_BFILL        = 3'd5;
  localparam logic [2:0] MODE_TWINKLE      = 3'd6;
  localparam logic [2:0] MODE_TWINKLE_HOLD = 3'd7;

  localparam logic [2:0] REG_BLINK_IV  = 3'd0;
  localparam logic [2:0] REG_MARQ_IV   = 3'd1;
  localparam logic [2:0] REG_RFILL_IV  = 3'd2;
  localparam logic [2:0] REG_BFILL_IV  = 3'd3;
  localparam logic [2:0] REG_TWK_IV    = 3'd4;
  localparam logic [2:0] REG_TWK_TH    = 3'd5;
  localparam logic [2:0] REG_DEB_TH    = 3'd6;

  localparam logic [4:0] RFILL_CAP = 5'd11;
  localparam logic [4:0] BFILL_CAP = 5'd24;

  typedef struct packed {
    logic func;
    logic button_level;
  } lpcc_in_t;

  typedef struct packed {
    logic [4:0]           pin_dir;
    logic [4:0]           pin_level;
    logic [2:0]           cur_mode;
    logic                 press_seen;
    logic [LED_COUNT-1:0] led_bits;
  } lpcc_out_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic count;
    logic render;
    logic div_step;
    logic twk_step;
    logic debounce;
    logic load_out;
  } lpcc_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       twk_go;
    logic       div_done;
    logic       twk_last;
  } lpcc_sts_t;

  function automatic logic [4:0] cathode_pin(input logic [LED_IDX_W-1:0] idx);
    logic [4:0] pin;
    unique case (idx) inside
      [5'd0:5'd3]:   pin = 5'h04;
      [5'd4:5'd7]:   pin = 5'h08;
      [5'd8:5'd11]:  pin = 5'h10;
      [5'd12:5'd15]: pin = 5'h02;
      [5'd16:5'd19]: pin = 5'h01;
      default:       pin = 5'h00;
    endcase
    return pin;
  endfunction

  function automatic logic [4:0] anode_pin(input logic [LED_IDX_W-1:0] idx);
    logic [4:0] pin;
    unique case (idx)
      5'd0:    pin = 5'h08;
      5'd1:    pin = 5'h10;
      5'd2:    pin = 5'h02;
      5'd3:    pin = 5'h01;
      5'd4:    pin = 5'h04;
      5'd5:    pin = 5'h10;
      5'd6:    pin = 5'h02;
      5'd7:    pin = 5'h01;
      5'd8:    pin = 5'h04;
      5'd9:    pin = 5'h08;
      5'd10:   pin = 5'h02;
      5'd11:   pin = 5'h01;
      5'd12:   pin = 5'h04;
      5'd13:   pin = 5'h08;
      5'd14:   pin = 5'h10;
      5'd15:   pin = 5'h01;
      5'd16:   pin = 5'h04;
      5'd17:   pin = 5'h08;
      5'd18:   pin = 5'h10;
      5'd19:   pin = 5'h02;
      default: pin = 5'h00;
    endcase
    return pin;
  endfunction

  function automatic logic [LED_COUNT-1:0] rfill_bits(input logic [4:0] q);
    logic [LED_COUNT-1:0] bits;
    bits = LED_COUNT'(1);
    if (q >= 5'd6) bits[15] = 1'b1;
    if (q >= 5'd5) begin
      bits[14] = 1'b1;
      bits[9]  = 1'b1;
    end
    if (q >= 5'd4) begin
      bits[13] = 1'b1;
      bits[8]  = 1'b1;
      bits[4]  = 1'b1;
    end
    if (q >= 5'd3) begin
      bits[12] = 1'b1;
      bits[7]  = 1'b1;
      bits[3]  = 1'b1;
    end
    if (q >= 5'd2) begin
      bits[11] = 1'b1;
      bits[6]  = 1'b1;
      bits[2]  = 1'b1;
    end
    if (q >= 5'd1) begin
      bits[10] = 1'b1;
      bits[5]  = 1'b1;
      bits[1]  = 1'b1;
    end
    return bits;
  endfunction

  function automatic logic [LED_COUNT-1:0] bfill_bits(input logic [4:0] q);
    logic [LED_COUNT-1:0] bits;
    bits = ALL_LEDS;
    for (int k = 1; k < LED_COUNT; k++) begin
      if (k + int'(q) <= 15) bits[k] = 1'b0;
    end
    return bits;
  endfunction

endpackage

// ===== src/lpcc_ctrl.sv =====
// Sequencing state machine and result handshake of the charlieplex LED controller.
module lpcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  output logic              out_valid,
  input  logic              out_ready,
  input  lpcc_pkg::lpcc_sts_t sts,
  output lpcc_pkg::lpcc_cmd_t cmd
);
  import lpcc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COUNT  = 3'd2;
  localparam logic [2:0] S_RENDER = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_TWK    = 3'd5;
  localparam logic [2:0] S_DEB    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_func ? S_SCAN : S_COUNT;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_DONE;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = S_RENDER;
      end
      S_RENDER: begin
        cmd.render = 1'b1;
        unique case (sts.mode) inside
          MODE_RFILL, MODE_BFILL:        state_nxt = S_DIV;
          MODE_TWINKLE, MODE_TWINKLE_HOLD: state_nxt = sts.twk_go ? S_TWK : S_DEB;
          default:                       state_nxt = S_DEB;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DEB;
      end
      S_TWK: begin
        cmd.twk_step = 1'b1;
        if (sts.twk_last) state_nxt = S_DEB;
      end
      S_DEB: begin
        cmd.debounce = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted request did not start work");

  a_twinkle_ends_in_debounce: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TWK && sts.twk_last |=> state_r == S_DEB)
    else $error("twinkle sweep did not hand over to debounce");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the completion state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.load_out)
    else $error("pending result overwritten");

endmodule

// ===== src/lpcc_dp.sv =====
// Datapath of the charlieplex LED controller: settings, pattern state, counters and result register.
module lpcc_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpcc_pkg::lpcc_cmd_t   cmd,
  output lpcc_pkg::lpcc_sts_t   sts,
  input  logic                  in_level,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output lpcc_pkg::lpcc_out_t   out_data
);
  import lpcc_pkg::*;

  localparam logic [1:0] DB_IDLE      = 2'd0;
  localparam logic [1:0] DB_WAIT_LOW  = 2'd1;
  localparam logic [1:0] DB_WAIT_HIGH = 2'd2;
  localparam logic [1:0] DB_END_HIGH  = 2'd3;

  logic [14:0] blink_iv_r, marq_iv_r;
  logic [15:0] rfill_iv_r, bfill_iv_r, twk_iv_r, twk_th_r;
  logic [7:0]  deb_th_r;

  logic [LED_COUNT-1:0] led_on_r, led_on_nxt;
  logic [15:0]          frame_cnt_r, frame_cnt_nxt;
  logic [7:0]           deb_cnt_r, deb_cnt_nxt;
  logic [1:0]           deb_phase_r, deb_phase_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic [15:0]          noise_r, noise_nxt;
  logic [LED_IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [4:0]           pin_dir_r, pin_dir_nxt;
  logic [4:0]           pin_level_r, pin_level_nxt;
  logic                 level_r, level_nxt;
  logic                 press_r, press_nxt;
  logic [15:0]          acc_r, acc_nxt;
  logic [4:0]           qcnt_r, qcnt_nxt;
  logic [LED_IDX_W-1:0] twk_idx_r, twk_idx_nxt;
  lpcc_out_t            out_data_r, out_data_nxt;

  logic [15:0] fill_iv;
  logic [4:0]  fill_cap;
  logic [16:0] acc_sum;
  logic [16:0] marq_x3;
  logic [15:0] noise_step;
  logic        deb_held;

  assign fill_iv    = (mode_r == MODE_RFILL) ? rfill_iv_r : bfill_iv_r;
  assign fill_cap   = (mode_r == MODE_RFILL) ? RFILL_CAP : BFILL_CAP;
  assign acc_sum    = {1'b0, acc_r} + {1'b0, fill_iv};
  assign marq_x3    = {2'b00, marq_iv_r} + {1'b0, marq_iv_r, 1'b0};
  assign noise_step = {noise_r[0] ^ noise_r[2] ^ noise_r[3] ^ noise_r[5], noise_r[15:1]};
  assign deb_held   = deb_cnt_r >= deb_th_r;

  assign sts.mode     = mode_r;
  assign sts.twk_go   = frame_cnt_r >= twk_iv_r;
  assign sts.div_done = (qcnt_r == fill_cap) || ({1'b0, frame_cnt_r} < acc_sum);
  assign sts.twk_last = twk_idx_r == LAST_LED;

  assign out_data = out_data_r;

  always_comb begin
    led_on_nxt    = led_on_r;
    frame_cnt_nxt = frame_cnt_r;
    deb_cnt_nxt   = deb_cnt_r;
    deb_phase_nxt = deb_phase_r;
    mode_nxt      = mode_r;
    noise_nxt     = noise_r;
    scan_idx_nxt  = scan_idx_r;
    pin_dir_nxt   = pin_dir_r;
    pin_level_nxt = pin_level_r;
    level_nxt     = level_r;
    press_nxt     = press_r;
    acc_nxt       = acc_r;
    qcnt_nxt      = qcnt_r;
    twk_idx_nxt   = twk_idx_r;
    out_data_nxt  = out_data_r;

    if (cmd.accept) level_nxt = in_level;

    if (cmd.scan) begin
      press_nxt     = 1'b0;
      pin_dir_nxt   = '0;
      pin_level_nxt = '0;
      if (int'(scan_idx_r) < LED_COUNT) begin
        pin_dir_nxt = cathode_pin(scan_idx_r);
        if (led_on_r[scan_idx_r]) begin
          pin_dir_nxt   = cathode_pin(scan_idx_r) | anode_pin(scan_idx_r);
          pin_level_nxt = anode_pin(scan_idx_r);
        end
      end
      scan_idx_nxt = (scan_idx_r >= LAST_LED) ? '0 : scan_idx_r + 1'b1;
    end

    if (cmd.count) begin
      frame_cnt_nxt = frame_cnt_r + 1'b1;
      deb_cnt_nxt   = deb_cnt_r + 1'b1;
      press_nxt     = 1'b0;
      acc_nxt       = '0;
      qcnt_nxt      = '0;
      twk_idx_nxt   = '0;
    end

    if (cmd.render) begin
      unique case (mode_r) inside
        MODE_OFF: begin
          led_on_nxt    = '0;
          frame_cnt_nxt = '0;
          pin_level_nxt = '0;
        end
        MODE_ON: begin
          led_on_nxt    = ALL_LEDS;
          frame_cnt_nxt = '0;
        end
        MODE_BLINK: begin
          if (frame_cnt_r >= {blink_iv_r, 1'b0}) frame_cnt_nxt = '0;
          else if (frame_cnt_r >= {1'b0, blink_iv_r}) led_on_nxt = ALL_LEDS;
          else led_on_nxt = '0;
        end
        MODE_MARQUEE: begin
          if ({1'b0, frame_cnt_r} >= marq_x3) begin
            frame_cnt_nxt = '0;
            led_on_nxt    = LED_COUNT'(1);
          end else if (frame_cnt_r >= {marq_iv_r, 1'b0}) begin
            led_on_nxt = LED_COUNT'(20'h09249);
          end else if (frame_cnt_r >= {1'b0, marq_iv_r}) begin
            led_on_nxt = LED_COUNT'(20'h04925);
          end else begin
            led_on_nxt = LED_COUNT'(20'h02493);
          end
        end
        MODE_RFILL, MODE_BFILL: begin
        end
        MODE_TWINKLE, MODE_TWINKLE_HOLD: begin
          if (sts.twk_go) frame_cnt_nxt = '0;
        end
      endcase
    end

    if (cmd.div_step) begin
      if (!sts.div_done) begin
        acc_nxt  = acc_sum[15:0];
        qcnt_nxt = qcnt_r + 1'b1;
      end else if (mode_r == MODE_RFILL) begin
        if (qcnt_r == RFILL_CAP) begin
          frame_cnt_nxt = '0;
          led_on_nxt    = LED_COUNT'(1);
        end else begin
          led_on_nxt = rfill_bits(qcnt_r);
        end
      end else begin
        if (qcnt_r == BFILL_CAP) begin
          frame_cnt_nxt = '0;
          led_on_nxt    = ALL_LEDS;
        end else begin
          led_on_nxt = bfill_bits(qcnt_r);
        end
      end
    end

    if (cmd.twk_step) begin
      noise_nxt = noise_step;
      if (noise_step > twk_th_r) led_on_nxt[twk_idx_r] = ~led_on_r[twk_idx_r];
      twk_idx_nxt = twk_idx_r + 1'b1;
    end

    if (cmd.debounce) begin
      if (mode_r == MODE_TWINKLE_HOLD) led_on_nxt[0] = 1'b1;
      unique case (deb_phase_r)
        DB_IDLE: begin
          if (!level_r) begin
            deb_cnt_nxt   = '0;
            deb_phase_nxt = DB_WAIT_LOW;
          end
        end
        DB_WAIT_LOW: begin
          if (deb_held && !level_r) begin
            deb_cnt_nxt   = '0;
            deb_phase_nxt = DB_WAIT_HIGH;
          end
        end
        DB_WAIT_HIGH: begin
          if (level_r) begin
            deb_cnt_nxt   = '0;
            deb_phase_nxt = DB_END_HIGH;
          end
        end
        DB_END_HIGH: begin
          if (deb_held && level_r) begin
            deb_cnt_nxt   = '0;
            deb_phase_nxt = DB_IDLE;
            press_nxt     = 1'b1;
            mode_nxt      = mode_r + 1'b1;
            frame_cnt_nxt = '0;
          end
        end
        default: deb_phase_nxt = DB_IDLE;
      endcase
    end

    if (cmd.load_out) begin
      out_data_nxt.pin_dir    = pin_dir_r;
      out_data_nxt.pin_level  = pin_level_r;
      out_data_nxt.cur_mode   = mode_r;
      out_data_nxt.press_seen = press_r;
      out_data_nxt.led_bits   = led_on_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_iv_r  <= 15'd750;
      marq_iv_r   <= 15'd500;
      rfill_iv_r  <= 16'd500;
      bfill_iv_r  <= 16'd300;
      twk_iv_r    <= 16'd500;
      twk_th_r    <= 16'd40000;
      deb_th_r    <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK_IV: blink_iv_r <= cfg_data[14:0];
        REG_MARQ_IV:  marq_iv_r  <= cfg_data[14:0];
        REG_RFILL_IV: rfill_iv_r <= cfg_data;
        REG_BFILL_IV: bfill_iv_r <= cfg_data;
        REG_TWK_IV:   twk_iv_r   <= cfg_data;
        REG_TWK_TH:   twk_th_r   <= cfg_data;
        REG_DEB_TH:   deb_th_r   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_on_r    <= '0;
      frame_cnt_r <= '0;
      deb_cnt_r   <= '0;
      deb_phase_r <= DB_IDLE;
      mode_r      <= MODE_ON;
      noise_r     <= NOISE_SEED;
      scan_idx_r  <= '0;
      pin_dir_r   <= '0;
      pin_level_r <= '0;
      press_r     <= 1'b0;
      qcnt_r      <= '0;
      twk_idx_r   <= '0;
    end else begin
      led_on_r    <= led_on_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      deb_cnt_r   <= deb_cnt_nxt;
      deb_phase_r <= deb_phase_nxt;
      mode_r      <= mode_nxt;
      noise_r     <= noise_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pin_dir_r   <= pin_dir_nxt;
      pin_level_r <= pin_level_nxt;
      press_r     <= press_nxt;
      qcnt_r      <= qcnt_nxt;
      twk_idx_r   <= twk_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  a_quotient_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> qcnt_r <= fill_cap)
    else $error("fill quotient ran past its cap");

  a_acc_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> acc_r <= frame_cnt_r)
    else $error("fill accumulator passed the frame count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(scan_idx_r) < LED_COUNT)
    else $error("scan index out of range");

endmodule

// ===== src/led_pattern_charlieplex_controller.sv =====
// Top level of the twenty-LED charlieplex pattern controller.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    lpcc_in_t  (func, button_level)
//   out_     output     out_valid / out_ready  lpcc_out_t (pins, mode, press, LEDs)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index (3 bit), cfg_data (16 bit)
//
// A scan request passes through the scan and completion states; a frame request passes
// through count, render and debounce, with the pattern work before debounce: the
// repeated-addition quotient in the fill modes (q up to 24), or one LFSR step per LED
// when a twinkle update is due; the result is loaded in the completion state.
// One request is in work at a time; a result still waiting holds the next request
// in its completion state until it is taken. Reset is synchronous, active low.
module led_pattern_charlieplex_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpcc_pkg::lpcc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpcc_pkg::lpcc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import lpcc_pkg::*;

  lpcc_cmd_t cmd;
  lpcc_sts_t sts;

  assign cfg_ready = 1'b1;

  lpcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpcc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_level  (in_data.button_level),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== dv/led_pattern_charlieplex_controller_test.sv =====
// Self-checking testbench of the charlieplex LED pattern controller.
package lpcc_test_pkg;
  import lpcc_pkg::*;

  localparam logic FUNC_FRAME     = 1'b0;
  localparam logic FUNC_SCAN      = 1'b1;
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef enum logic [1:0] {
    DEB_IDLE,
    DEB_WAIT_LOW,
    DEB_WAIT_HIGH,
    DEB_END_HIGH
  } debounce_phase_e;

  class charlieplex_board;
    logic [14:0]          blink_iv;
    logic [14:0]          marquee_iv;
    logic [15:0]          rfill_iv;
    logic [15:0]          bfill_iv;
    logic [15:0]          twinkle_iv;
    logic [15:0]          twinkle_th;
    logic [7:0]           debounce_th;

    logic [LED_COUNT-1:0] leds;
    logic [15:0]          frames;
    logic [7:0]           settle;
    debounce_phase_e      phase;
    logic [2:0]           mode;
    logic [15:0]          noise;
    logic [4:0]           scan_pos;
    logic [4:0]           dir_held;
    logic [4:0]           level_held;
    logic [4:0]           cathode_of [LED_COUNT];
    logic [4:0]           anode_of [LED_COUNT];

    lpcc_out_t            pending_results [$];
    int unsigned          failures;
    int unsigned          checked;
    int unsigned          frames_seen;
    int unsigned          scans_seen;
    int unsigned          presses_seen;
    logic [7:0]           modes_seen;

    function new();
      cathode_of = '{5'h04, 5'h04, 5'h04, 5'h04, 5'h08, 5'h08, 5'h08, 5'h08, 5'h10, 5'h10,
                     5'h10, 5'h10, 5'h02, 5'h02, 5'h02, 5'h02, 5'h01, 5'h01, 5'h01, 5'h01};
      anode_of   = '{5'h08, 5'h10, 5'h02, 5'h01, 5'h04, 5'h10, 5'h02, 5'h01, 5'h04, 5'h08,
                     5'h02, 5'h01, 5'h04, 5'h08, 5'h10, 5'h01, 5'h04, 5'h08, 5'h10, 5'h02};
      blink_iv     = 15'd750;
      marquee_iv   = 15'd500;
      rfill_iv     = 16'd500;
      bfill_iv     = 16'd300;
      twinkle_iv   = 16'd500;
      twinkle_th   = 16'd40000;
      debounce_th  = 8'd5;
      leds         = '0;
      frames       = '0;
      settle       = '0;
      phase        = DEB_IDLE;
      mode         = MODE_ON;
      noise        = NOISE_SEED;
      scan_pos     = '0;
      dir_held     = '0;
      level_held   = '0;
      failures     = 0;
      checked      = 0;
      frames_seen  = 0;
      scans_seen   = 0;
      presses_seen = 0;
      modes_seen   = '0;
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_BLINK_IV: blink_iv    = data[14:0];
        REG_MARQ_IV:  marquee_iv  = data[14:0];
        REG_RFILL_IV: rfill_iv    = data;
        REG_BFILL_IV: bfill_iv    = data;
        REG_TWK_IV:   twinkle_iv  = data;
        REG_TWK_TH:   twinkle_th  = data;
        REG_DEB_TH:   debounce_th = data[7:0];
        default: ;
      endcase
    endfunction

    // A zero interval gives a step count beyond any fill, so the frame count restarts.
    function int unsigned fill_step(logic [15:0] iv);
      return (iv == 16'd0) ? 32'hFFFF : 32'(frames) / 32'(iv);
    endfunction

    function void twinkle();
      if (frames >= twinkle_iv) begin
        frames = '0;
        for (int i = 0; i < LED_COUNT; i++) begin
          noise = {noise[0] ^ noise[2] ^ noise[3] ^ noise[5], noise[15:1]};
          if (noise > twinkle_th) leds[i] = ~leds[i];
        end
      end
    endfunction

    function void render_pattern();
      int unsigned fc;
      int unsigned q;
      int unsigned k;
      fc = 32'(frames);
      case (mode)
        MODE_OFF: begin
          leds       = '0;
          frames     = '0;
          level_held = '0;
        end
        MODE_ON: begin
          leds   = ALL_LEDS;
          frames = '0;
        end
        MODE_BLINK: begin
          if (fc >= 2 * 32'(blink_iv)) frames = '0;
          else if (fc >= 32'(blink_iv)) leds = ALL_LEDS;
          else leds = '0;
        end
        MODE_MARQUEE: begin
          leds = 20'd1;
          if (fc >= 3 * 32'(marquee_iv)) frames = '0;
          else if (fc >= 2 * 32'(marquee_iv)) leds |= 20'h09248;
          else if (fc >= 32'(marquee_iv)) leds |= 20'h04924;
          else leds |= 20'h02492;
        end
        MODE_RFILL: begin
          leds = 20'd1;
          q = fill_step(rfill_iv);
          if (q > 10) begin
            frames = '0;
          end else begin
            if (q >= 1) leds |= 20'h00422;
            if (q >= 2) leds |= 20'h00844;
            if (q >= 3) leds |= 20'h01088;
            if (q >= 4) leds |= 20'h02110;
            if (q >= 5) leds |= 20'h04200;
            if (q >= 6) leds |= 20'h08000;
          end
        end
        MODE_BFILL: begin
          leds = ALL_LEDS;
          q = fill_step(bfill_iv);
          if (q > 23) frames = '0;
          else for (k = 1; k + q <= 15; k++) leds[k] = 1'b0;
        end
        MODE_TWINKLE: twinkle();
        default: begin
          twinkle();
          leds[0] = 1'b1;
        end
      endcase
    endfunction

    function logic step_debounce(logic level);
      case (phase)
        DEB_IDLE: begin
          if (level == LEVEL_PRESSED) begin
            settle = '0;
            phase  = DEB_WAIT_LOW;
          end
        end
        DEB_WAIT_LOW: begin
          if (settle >= debounce_th && level == LEVEL_PRESSED) begin
            settle = '0;
            phase  = DEB_WAIT_HIGH;
          end
        end
        DEB_WAIT_HIGH: begin
          if (level == LEVEL_RELEASED) begin
            settle = '0;
            phase  = DEB_END_HIGH;
          end
        end
        default: begin
          if (settle >= debounce_th && level == LEVEL_RELEASED) begin
            settle = '0;
            phase  = DEB_IDLE;
            return 1'b1;
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void note_request(lpcc_in_t req);
      lpcc_out_t want;
      logic      press;
      press = 1'b0;
      if (req.func == FUNC_FRAME) begin
        frames_seen++;
        frames = frames + 16'd1;
        settle = settle + 8'd1;
        render_pattern();
        press = step_debounce(req.button_level);
        if (press) begin
          mode   = mode + 3'd1;
          frames = '0;
          presses_seen++;
        end
      end else begin
        scans_seen++;
        dir_held   = '0;
        level_held = '0;
        if (scan_pos < LED_COUNT) begin
          dir_held = cathode_of[scan_pos];
          if (leds[scan_pos]) begin
            dir_held   |= anode_of[scan_pos];
            level_held  = anode_of[scan_pos];
          end
        end
        scan_pos = (scan_pos >= LAST_LED) ? 5'd0 : scan_pos + 5'd1;
      end
      modes_seen[mode] = 1'b1;
      want.pin_dir    = dir_held;
      want.pin_level  = level_held;
      want.cur_mode   = mode;
      want.press_seen = press;
      want.led_bits   = leds;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [19:0] want, logic [19:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(lpcc_out_t got);
      lpcc_out_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result expected none, got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("pin_dir", 20'(want.pin_dir), 20'(got.pin_dir));
      compare_field("pin_level", 20'(want.pin_level), 20'(got.pin_level));
      compare_field("cur_mode", 20'(want.cur_mode), 20'(got.cur_mode));
      compare_field("press_seen", 20'(want.press_seen), 20'(got.press_seen));
      compare_field("led_bits", want.led_bits, got.led_bits);
    endfunction
  endclass

endpackage

module led_pattern_charlieplex_controller_test;
  import lpcc_pkg::*;
  import lpcc_test_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1850;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [2:0]  REG_UNUSED    = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  lpcc_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  lpcc_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  charlieplex_board board;
  bit               calm;
  int unsigned      requests_sent;
  int unsigned      settings_applied;
  logic [15:0]      next_setting [REG_BLINK_IV:REG_DEB_TH];

  led_pattern_charlieplex_controller u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 12);
  endfunction

  function automatic logic [15:0] pick_value(input int unsigned small_hi);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    if (roll == 2) return 16'($urandom);
    return 16'($urandom_range(1, small_hi));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    out_ready <= !take_break();
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(input lpcc_in_t req);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(req);
    requests_sent++;
  endtask

  task automatic send_frame(input logic level);
    send_request(lpcc_in_t'{func: FUNC_FRAME, button_level: level});
  endtask

  task automatic send_scan();
    send_request(lpcc_in_t'{func: FUNC_SCAN, button_level: 1'($urandom)});
  endtask

  task automatic hold_level(input logic level, input int unsigned count, input bit with_scans);
    repeat (count) begin
      if (with_scans && $urandom_range(0, 4) == 0) send_scan();
      send_frame(level);
    end
  endtask

  // A broken press lets go before the debounce count is reached.
  task automatic press_button(input bit broken);
    int unsigned th;
    th = 32'(board.debounce_th);
    if (broken && th > 0) begin
      hold_level(LEVEL_PRESSED, $urandom_range(1, th), 1'b1);
      hold_level(LEVEL_RELEASED, $urandom_range(1, th + 1), 1'b1);
    end else begin
      hold_level(LEVEL_PRESSED, th + 1 + $urandom_range(0, 2), 1'b1);
      hold_level(LEVEL_RELEASED, th + 1 + $urandom_range(0, 2), 1'b1);
    end
  endtask

  task automatic run_mix(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) press_button(1'b0);
      else if (pick < 70) repeat ($urandom_range(1, 24)) send_scan();
      else if (pick < 88) repeat ($urandom_range(1, 8)) send_frame(1'($urandom));
      else press_button(1'b1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_register(idx, data);
  endtask

  task automatic apply_settings();
    wait_idle();
    for (int r = REG_BLINK_IV; r <= REG_DEB_TH; r++) write_register(3'(r), next_setting[r]);
    write_register(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  initial begin : stimulus
    board            = new();
    calm             = 1'b0;
    requests_sent    = 0;
    settings_applied = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_scan();
    send_scan();
    send_frame(LEVEL_RELEASED);
    send_scan();
    send_scan();
    hold_level(LEVEL_PRESSED, board.debounce_th + 1, 1'b0);
    hold_level(LEVEL_RELEASED, board.debounce_th + 1, 1'b0);
    send_frame(LEVEL_RELEASED);
    send_frame(LEVEL_PRESSED);

    foreach (next_setting[r]) next_setting[r] = 16'd0;
    apply_settings();
    run_mix(PHASE_ITEMS);

    foreach (next_setting[r]) next_setting[r] = 16'hFFFF;
    apply_settings();
    run_mix(PHASE_ITEMS);

    while (requests_sent < ITEM_TARGET) begin
      next_setting[REG_BLINK_IV] = pick_value(8);
      next_setting[REG_MARQ_IV]  = pick_value(5);
      next_setting[REG_RFILL_IV] = pick_value(4);
      next_setting[REG_BFILL_IV] = pick_value(3);
      next_setting[REG_TWK_IV]   = pick_value(6);
      next_setting[REG_TWK_TH]   = 16'($urandom);
      next_setting[REG_DEB_TH]   = 16'($urandom_range(0, 3));
      apply_settings();
      calm = (settings_applied == 3);
      run_mix(PHASE_ITEMS);
    end

    calm = 1'b0;
    wait_idle();
    $display("Run covered %0d frame and %0d scan requests over %0d register settings.",
             board.frames_seen, board.scans_seen, settings_applied);
    $display("%0d results checked, %0d debounced presses, modes visited %b, %0d mismatches.",
             board.checked, board.presses_seen, board.modes_seen, board.failures);
    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
